### rtl/spq_pkg.sv
package spq_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_CAPACITY     = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Fixed field widths of the stream items.
    localparam int KIND_W   = 3;
    localparam int PRI_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes carried in the input tuser.
    localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_EQ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_GE   = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_KEEP,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_op;

    // Compare results that a cell reports against the current key.
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cell_flags;

endpackage

### rtl/sorted_priority_queue_top.sv
// An accepted item is held in the request registers and executed, and its result item
// is registered for output. Pop equal-or-higher without an exact match first retries as
// an exact pop of the smallest priority above the key; remove not-less drops the head one
// entry per cycle while it is not below the key. Items are taken one at a time.
// Reset (synchronous, active low) empties the queue, holds input ready low and clears
// the result valid; the cell contents are not reset.
module sorted_priority_queue_top #(
    parameter int CAPACITY     = spq_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // priority_req[7:0], payload_in[39:8]
    input  logic [2:0]  s_axis_tuser,  // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // payload_out[31:0], priority_out[39:32],
                                       // occupancy[44:40], zero[47:45]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (PAYLOAD_BITS > spq_pkg::WORD_W) ? PAYLOAD_BITS : spq_pkg::WORD_W;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                              r_state;
    logic [spq_pkg::KIND_W-1:0]        r_kind;
    logic [spq_pkg::PRI_W-1:0]         r_key;
    logic [PAYLOAD_BITS-1:0]           r_pay;
    logic                              r_found;
    logic [CW-1:0]                     r_count;
    logic                              r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]      r_out_status;
    logic [spq_pkg::WORD_W-1:0]        r_out_pay;
    logic [spq_pkg::PRI_W-1:0]         r_out_pri;
    logic [spq_pkg::OCC_W-1:0]         r_out_occ;

    logic [spq_pkg::KIND_W-1:0]        n_kind;
    logic [spq_pkg::PRI_W-1:0]         n_key;
    logic                              n_found;
    logic [CW-1:0]                     n_count;
    logic                              done;
    logic [spq_pkg::STATUS_W-1:0]      res_status;
    logic [PAYLOAD_BITS-1:0]           res_pay;
    logic [spq_pkg::PRI_W-1:0]         res_pri;
    logic                              accept;
    logic [XW-1:0]                     in_wide;
    logic [XW-1:0]                     out_wide;

    spq_pkg::t_cell_op                 cell_op  [CAPACITY];
    spq_pkg::t_cell_flags              flags    [CAPACITY];
    logic                              valid    [CAPACITY];
    logic [spq_pkg::PRI_W-1:0]         cell_pri [CAPACITY];
    logic [PAYLOAD_BITS-1:0]           cell_pay [CAPACITY];

    logic                              ins      [CAPACITY];
    logic                              first_eq [CAPACITY];
    logic                              last_gt  [CAPACITY];
    logic                              any_eq;
    logic                              any_gt;
    logic [spq_pkg::PRI_W-1:0]         eq_pri;
    logic [PAYLOAD_BITS-1:0]           eq_pay;
    logic [spq_pkg::PRI_W-1:0]         gt_pri;
    logic                              kind_known;

    // Input handshake: take an item when idle and the result slot frees up.
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_wide       = XW'(s_axis_tdata[39:8]);

    // The row of cells; each talks only to its neighboring cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign valid[g] = (CW'(g) < r_count);
        if (g == 0) begin : g_first
            spq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_valid     (valid[g]),
                .i_key       (r_key),
                .i_op        (cell_op[g]),
                .i_new_pri   (r_key),
                .i_new_pay   (r_pay),
                .i_left_pri  ('0),
                .i_left_pay  ('0),
                .i_right_pri (cell_pri[g+1]),
                .i_right_pay (cell_pay[g+1]),
                .o_flags     (flags[g]),
                .o_pri       (cell_pri[g]),
                .o_pay       (cell_pay[g])
            );
        end else if (g == CAPACITY - 1) begin : g_last
            spq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_valid     (valid[g]),
                .i_key       (r_key),
                .i_op        (cell_op[g]),
                .i_new_pri   (r_key),
                .i_new_pay   (r_pay),
                .i_left_pri  (cell_pri[g-1]),
                .i_left_pay  (cell_pay[g-1]),
                .i_right_pri ('0),
                .i_right_pay ('0),
                .o_flags     (flags[g]),
                .o_pri       (cell_pri[g]),
                .o_pay       (cell_pay[g])
            );
        end else begin : g_mid
            spq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_valid     (valid[g]),
                .i_key       (r_key),
                .i_op        (cell_op[g]),
                .i_new_pri   (r_key),
                .i_new_pay   (r_pay),
                .i_left_pri  (cell_pri[g-1]),
                .i_left_pay  (cell_pay[g-1]),
                .i_right_pri (cell_pri[g+1]),
                .i_right_pay (cell_pay[g+1]),
                .o_flags     (flags[g]),
                .o_pri       (cell_pri[g]),
                .o_pay       (cell_pay[g])
            );
        end
    end

    // Boundary marks from neighboring flags, and the entries they select.
    always_comb begin
        any_eq = 1'b0;
        any_gt = 1'b0;
        eq_pri = '0;
        eq_pay = '0;
        gt_pri = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ins[i]      = !(flags[i].gt || flags[i].eq);
            first_eq[i] = flags[i].eq && ((i == 0) ? 1'b1 : !flags[(i == 0) ? 0 : i-1].eq);
            last_gt[i]  = flags[i].gt &&
                          ((i == CAPACITY - 1) ? 1'b1
                                               : !flags[(i == CAPACITY - 1) ? i : i+1].gt);
            any_eq      = any_eq | flags[i].eq;
            any_gt      = any_gt | flags[i].gt;
            eq_pri      = eq_pri | (cell_pri[i] & {spq_pkg::PRI_W{first_eq[i]}});
            eq_pay      = eq_pay | (cell_pay[i] & {PAYLOAD_BITS{first_eq[i]}});
            gt_pri      = gt_pri | (cell_pri[i] & {spq_pkg::PRI_W{last_gt[i]}});
        end
    end

    assign kind_known = (r_kind == spq_pkg::KIND_POP_HEAD) || (r_kind == spq_pkg::KIND_POP_EQ) ||
                        (r_kind == spq_pkg::KIND_REMOVE) || (r_kind == spq_pkg::KIND_POP_GE);

    // Operation sequencer: drives every cell and forms the result.
    always_comb begin
        n_kind     = r_kind;
        n_key      = r_key;
        n_found    = r_found;
        n_count    = r_count;
        done       = 1'b0;
        res_status = spq_pkg::ST_OK;
        res_pay    = '0;
        res_pri    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = spq_pkg::CELL_KEEP;
        end
        if (r_state == S_EXEC) begin
            priority if (r_kind == spq_pkg::KIND_INSERT) begin
                done = 1'b1;
                if (r_count == CW'(CAPACITY)) begin
                    res_status = spq_pkg::ST_FULL;
                end else begin
                    // Cells below the new entry move one slot down.
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (ins[i] && ((i == 0) ? 1'b1 : !ins[(i == 0) ? 0 : i-1])) begin
                            cell_op[i] = spq_pkg::CELL_LOAD;
                        end else if (ins[i]) begin
                            cell_op[i] = spq_pkg::CELL_LEFT;
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end else if (!kind_known) begin
                done       = 1'b1;
                res_status = spq_pkg::ST_NOMATCH;
            end else if (r_count == '0) begin
                // A remove that emptied the queue still reports success.
                done       = 1'b1;
                res_status = (r_kind == spq_pkg::KIND_REMOVE && r_found) ? spq_pkg::ST_OK
                                                                         : spq_pkg::ST_EMPTY;
            end else if (r_kind == spq_pkg::KIND_POP_HEAD) begin
                done    = 1'b1;
                res_pri = cell_pri[0];
                res_pay = cell_pay[0];
                n_count = r_count - 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    cell_op[i] = spq_pkg::CELL_RIGHT;
                end
            end else if (r_kind == spq_pkg::KIND_REMOVE) begin
                // Drop the head one cycle at a time while it is not below the key.
                if (flags[0].gt || flags[0].eq) begin
                    n_found = 1'b1;
                    n_count = r_count - 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        cell_op[i] = spq_pkg::CELL_RIGHT;
                    end
                end else begin
                    done       = 1'b1;
                    res_status = r_found ? spq_pkg::ST_OK : spq_pkg::ST_NOMATCH;
                end
            end else if (any_eq) begin
                // Oldest exact match leaves; the cells behind it close the gap.
                done    = 1'b1;
                res_pri = eq_pri;
                res_pay = eq_pay;
                n_count = r_count - 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!flags[i].gt) begin
                        cell_op[i] = spq_pkg::CELL_RIGHT;
                    end
                end
            end else if (r_kind == spq_pkg::KIND_POP_GE && any_gt) begin
                // Retry as an exact pop of the smallest priority above the key.
                n_key  = gt_pri;
                n_kind = spq_pkg::KIND_POP_EQ;
            end else begin
                done       = 1'b1;
                res_status = spq_pkg::ST_NOMATCH;
            end
        end
    end

    // Control and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= S_EXEC;
                r_found <= 1'b0;
            end else begin
                if (done) begin
                    r_state <= S_IDLE;
                end
                r_found <= n_found;
            end
            r_count <= n_count;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_key  <= s_axis_tdata[7:0];
            r_pay  <= in_wide[PAYLOAD_BITS-1:0];
        end else begin
            r_kind <= n_kind;
            r_key  <= n_key;
        end
        if (done) begin
            r_out_status <= res_status;
            r_out_pay    <= out_wide[spq_pkg::WORD_W-1:0];
            r_out_pri    <= res_pri;
            r_out_occ    <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign out_wide = XW'(res_pay);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_occ, r_out_pri, r_out_pay};

endmodule

### rtl/spq_cell.sv
module spq_cell #(
    parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_valid,
    input  logic [spq_pkg::PRI_W-1:0] i_key,
    input  spq_pkg::t_cell_op         i_op,
    input  logic [spq_pkg::PRI_W-1:0] i_new_pri,
    input  logic [PAYLOAD_BITS-1:0]   i_new_pay,
    input  logic [spq_pkg::PRI_W-1:0] i_left_pri,
    input  logic [PAYLOAD_BITS-1:0]   i_left_pay,
    input  logic [spq_pkg::PRI_W-1:0] i_right_pri,
    input  logic [PAYLOAD_BITS-1:0]   i_right_pay,
    output spq_pkg::t_cell_flags      o_flags,
    output logic [spq_pkg::PRI_W-1:0] o_pri,
    output logic [PAYLOAD_BITS-1:0]   o_pay
);

    logic [spq_pkg::PRI_W-1:0] r_pri;
    logic [PAYLOAD_BITS-1:0]   r_pay;

    // Compare the held entry with the key; an empty cell reports neither.
    always_comb begin
        o_flags.gt = i_valid && (r_pri > i_key);
        o_flags.eq = i_valid && (r_pri == i_key);
    end

    // Hold, load the new entry, or take a neighbor's entry.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            spq_pkg::CELL_LOAD: begin
                r_pri <= i_new_pri;
                r_pay <= i_new_pay;
            end
            spq_pkg::CELL_LEFT: begin
                r_pri <= i_left_pri;
                r_pay <= i_left_pay;
            end
            spq_pkg::CELL_RIGHT: begin
                r_pri <= i_right_pri;
                r_pay <= i_right_pay;
            end
            default: begin
                r_pri <= r_pri;
                r_pay <= r_pay;
            end
        endcase
    end

    assign o_pri = r_pri;
    assign o_pay = r_pay;

endmodule

### rtl/spq_checker.sv
module spq_checker #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(CAPACITY);

    // A waiting result item stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped before it was taken");

    // A new item is only taken when the result slot is free or emptying.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("item accepted while a result was stalled");

    // A dropped insert means the queue was full.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == spq_pkg::ST_FULL |-> m_axis_tdata[44:40] == FULL_OCC)
        else $error("full status with the queue not full");

    // Failed operations carry no entry.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != spq_pkg::ST_OK |-> m_axis_tdata[39:0] == 40'd0)
        else $error("failed operation returned an entry");

    // No item is taken in the cycle right after one was taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while the first is in progress");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = spq_pkg::DEF_CAPACITY;
    localparam int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 48;
    localparam int PAD_LO       = spq_pkg::WORD_W + spq_pkg::PRI_W + spq_pkg::OCC_W;
    localparam int TOTAL_ITEMS  = 1050;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int POOL_N       = 6;

    // Kind codes that the block does not implement.
    localparam logic [spq_pkg::KIND_W-1:0] KIND_FIRST_BAD = spq_pkg::KIND_POP_GE + 1'b1;
    localparam logic [spq_pkg::KIND_W-1:0] KIND_LAST_BAD  = {spq_pkg::KIND_W{1'b1}};

    // Payload bits that the store keeps.
    localparam logic [spq_pkg::WORD_W-1:0] WORD_MASK =
        spq_pkg::WORD_W'((65'h1 << PAYLOAD_BITS) - 1);

    // One result item as the block should deliver it.
    typedef struct {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::WORD_W-1:0]   word;
        logic [spq_pkg::PRI_W-1:0]    prio;
        logic [spq_pkg::OCC_W-1:0]    held;
    } t_queue_result;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // Sorted store of the expected queue and the results it predicts.
    class queue_scoreboard;
        logic [spq_pkg::PRI_W-1:0]  held_prio [CAPACITY];
        logic [spq_pkg::WORD_W-1:0] held_word [CAPACITY];
        int unsigned                held_count;
        t_queue_result              awaited_results [$];
        int unsigned                mismatches;
        int unsigned                checked;
        int unsigned                status_seen [4];

        function new();
            held_count = 0;
            mismatches = 0;
            checked    = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        task report_mismatch(input string what);
            if (mismatches < 30) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
            mismatches++;
        endtask

        // Apply one accepted operation to the store and queue its result.
        function void note_request(input logic [spq_pkg::KIND_W-1:0] kind,
                                   input logic [spq_pkg::PRI_W-1:0] key,
                                   input logic [spq_pkg::WORD_W-1:0] word);
            t_queue_result res;
            int unsigned   pos;
            int unsigned   kept;
            int unsigned   i;
            bit            hit;
            res.status = spq_pkg::ST_OK;
            res.word   = '0;
            res.prio   = '0;
            hit        = 1'b0;
            pos        = 0;
            if (kind == spq_pkg::KIND_INSERT) begin
                if (held_count >= CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    // New entry goes behind every entry of equal or higher priority.
                    pos = held_count;
                    for (i = 0; i < held_count; i++) begin
                        if (held_prio[i] < key) begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = held_count; i > pos; i--) begin
                        held_prio[i] = held_prio[i-1];
                        held_word[i] = held_word[i-1];
                    end
                    held_prio[pos] = key;
                    held_word[pos] = word & WORD_MASK;
                    held_count++;
                end
            end else if (kind > spq_pkg::KIND_POP_GE) begin
                res.status = spq_pkg::ST_NOMATCH;
            end else if (held_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else if (kind == spq_pkg::KIND_REMOVE) begin
                // Keep only the entries below the key, in order.
                kept = 0;
                for (i = 0; i < held_count; i++) begin
                    if (held_prio[i] >= key) begin
                        hit = 1'b1;
                    end else begin
                        held_prio[kept] = held_prio[i];
                        held_word[kept] = held_word[i];
                        kept++;
                    end
                end
                held_count = kept;
                res.status = hit ? spq_pkg::ST_OK : spq_pkg::ST_NOMATCH;
            end else begin
                if (kind == spq_pkg::KIND_POP_HEAD) begin
                    hit = 1'b1;
                end else begin
                    for (i = 0; i < held_count; i++) begin
                        if (held_prio[i] == key) begin
                            hit = 1'b1;
                            pos = i;
                            break;
                        end
                    end
                    // No exact match: the oldest entry of the smallest priority above the key.
                    if (!hit && kind == spq_pkg::KIND_POP_GE) begin
                        for (i = 0; i < held_count; i++) begin
                            if (held_prio[i] > key) begin
                                hit = 1'b1;
                                pos = i;
                            end
                        end
                        while (hit && pos > 0 && held_prio[pos-1] == held_prio[pos]) begin
                            pos--;
                        end
                    end
                end
                if (hit) begin
                    res.word = held_word[pos];
                    res.prio = held_prio[pos];
                    for (i = pos; i + 1 < held_count; i++) begin
                        held_prio[i] = held_prio[i+1];
                        held_word[i] = held_word[i+1];
                    end
                    held_count--;
                end else begin
                    res.status = spq_pkg::ST_NOMATCH;
                end
            end
            res.held = spq_pkg::OCC_W'(held_count);
            awaited_results.push_back(res);
        endfunction

        // Compare one delivered result with the oldest one awaited.
        task check_response(input logic [spq_pkg::STATUS_W-1:0] status,
                            input logic [OUT_W-1:0] data);
            t_queue_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result item with no operation outstanding");
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            end
            if (data[spq_pkg::WORD_W-1:0] !== want.word) begin
                report_mismatch($sformatf("payload %h, expected %h",
                                          data[spq_pkg::WORD_W-1:0], want.word));
            end
            if (data[spq_pkg::WORD_W +: spq_pkg::PRI_W] !== want.prio) begin
                report_mismatch($sformatf("priority %0d, expected %0d",
                                          data[spq_pkg::WORD_W +: spq_pkg::PRI_W],
                                          want.prio));
            end
            if (data[spq_pkg::WORD_W+spq_pkg::PRI_W +: spq_pkg::OCC_W] !== want.held) begin
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          data[spq_pkg::WORD_W+spq_pkg::PRI_W +: spq_pkg::OCC_W],
                                          want.held));
            end
            if (data[OUT_W-1:PAD_LO] !== '0) begin
                report_mismatch($sformatf("padding bits %b not zero", data[OUT_W-1:PAD_LO]));
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_W-1:0]            s_axis_tdata = '0;   // priority_req[7:0], payload_in[39:8]
    logic [spq_pkg::KIND_W-1:0] s_axis_tuser = '0;   // kind[2:0]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_W-1:0]           m_axis_tdata;        // payload_out, priority_out, occupancy
    logic [1:0]                 m_axis_tuser;        // status[1:0]

    queue_scoreboard            sb;
    int unsigned                n_sent = 0;
    int unsigned                burst_left = 0;
    int unsigned                cycle_count = 0;
    logic [spq_pkg::PRI_W-1:0]  key_pool [POOL_N];
    t_rx_mode                   rx_mode = RX_ALWAYS;
    int unsigned                rx_left = 0;

    sorted_priority_queue_top #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one item in bursts with random gaps, and hold it until taken.
    task automatic send_item(input logic [spq_pkg::KIND_W-1:0] kind,
                             input logic [spq_pkg::PRI_W-1:0] key,
                             input logic [spq_pkg::WORD_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {$urandom, 8'($urandom)};
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {word, key};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, key, word);
        n_sent++;
    endtask

    // New set of likely priorities, so that equal keys meet often.
    task automatic refresh_pool();
        foreach (key_pool[k]) key_pool[k] = spq_pkg::PRI_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: key_pool[0] = '0;
            1: key_pool[0] = '1;
            default: ;
        endcase
    endtask

    // Keys mostly hit the pool or a priority that is already held.
    function automatic logic [spq_pkg::PRI_W-1:0] pick_key();
        logic [spq_pkg::PRI_W-1:0] held;
        held = spq_pkg::PRI_W'($urandom_range(0, 255));
        if (sb.held_count > 0) begin
            held = sb.held_prio[$urandom_range(0, sb.held_count - 1)];
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return key_pool[$urandom_range(0, POOL_N - 1)];
            4, 5:       return held;
            6:          return (held == '0) ? held : held - 1'b1;
            default:    return spq_pkg::PRI_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [spq_pkg::KIND_W-1:0] pick_pop();
        case ($urandom_range(0, 3))
            0:       return spq_pkg::KIND_POP_HEAD;
            1:       return spq_pkg::KIND_POP_EQ;
            2:       return spq_pkg::KIND_REMOVE;
            default: return spq_pkg::KIND_POP_GE;
        endcase
    endfunction

    function automatic logic [spq_pkg::KIND_W-1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return spq_pkg::KIND_INSERT;
        if (roll < 60) return spq_pkg::KIND_POP_HEAD;
        if (roll < 73) return spq_pkg::KIND_POP_EQ;
        if (roll < 80) return spq_pkg::KIND_REMOVE;
        if (roll < 94) return spq_pkg::KIND_POP_GE;
        return spq_pkg::KIND_W'($urandom_range(KIND_FIRST_BAD, KIND_LAST_BAD));
    endfunction

    // Receiver readiness follows a pattern that changes every so often.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_axis_tready <= (cycle_count % 5 != 2);
        endcase
    end

    // Every result item taken by the receiver is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_response(m_axis_tuser, m_axis_tdata);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        sb = new();
        refresh_pool();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every pop and remove kind on an empty queue, and an unknown kind.
        send_item(spq_pkg::KIND_POP_HEAD, 8'd0, 32'h0);
        send_item(spq_pkg::KIND_POP_EQ, 8'd0, 32'h0);
        send_item(spq_pkg::KIND_REMOVE, 8'd0, 32'h0);
        send_item(spq_pkg::KIND_POP_GE, 8'd255, 32'h0);
        send_item(KIND_LAST_BAD, 8'd0, 32'hffff_ffff);

        // Extremes of priority and payload, and two entries of equal priority.
        send_item(spq_pkg::KIND_INSERT, 8'd255, 32'hffff_ffff);
        send_item(spq_pkg::KIND_INSERT, 8'd0, 32'h0000_0000);
        send_item(spq_pkg::KIND_INSERT, 8'd128, 32'h1111_aaaa);
        send_item(spq_pkg::KIND_INSERT, 8'd128, 32'h2222_5555);
        send_item(spq_pkg::KIND_INSERT, 8'd200, 32'h3333_cccc);

        // Exact pops, nearest-above pops and their misses.
        send_item(spq_pkg::KIND_POP_EQ, 8'd77, 32'h0);
        send_item(spq_pkg::KIND_POP_EQ, 8'd128, 32'h0);
        send_item(spq_pkg::KIND_POP_GE, 8'd100, 32'h0);
        send_item(spq_pkg::KIND_POP_GE, 8'd255, 32'h0);
        send_item(spq_pkg::KIND_POP_GE, 8'd201, 32'h0);

        // Removal that finds nothing, then one that does; then unknown kinds and two more pops.
        send_item(spq_pkg::KIND_REMOVE, 8'd250, 32'h0);
        send_item(spq_pkg::KIND_REMOVE, 8'd100, 32'h0);
        send_item(KIND_FIRST_BAD, 8'd3, 32'h0);
        send_item(KIND_LAST_BAD - 1'b1, 8'd9, 32'h0);
        send_item(spq_pkg::KIND_POP_HEAD, 8'd0, 32'h0);
        send_item(spq_pkg::KIND_POP_GE, 8'd0, 32'h0);

        // Random episodes: filling past capacity, draining, and mixed traffic.
        while (n_sent < TOTAL_ITEMS) begin
            refresh_pool();
            case ($urandom_range(0, 3))
                0: begin
                    n = CAPACITY - sb.held_count + $urandom_range(1, 3);
                    repeat (n) send_item(spq_pkg::KIND_INSERT, pick_key(), $urandom);
                end
                1: begin
                    n = $urandom_range(4, 20);
                    repeat (n) send_item(pick_pop(), pick_key(), $urandom);
                end
                default: begin
                    n = $urandom_range(5, 30);
                    repeat (n) send_item(pick_kind(), pick_key(), $urandom);
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // Let the last results come out, then a quiet tail.
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operations sent, %0d results checked in %0d cycles",
                 n_sent, sb.checked, cycle_count);
        $display("results by status: %0d ok, %0d empty, %0d no match, %0d full; %0d mismatches",
                 sb.status_seen[spq_pkg::ST_OK], sb.status_seen[spq_pkg::ST_EMPTY],
                 sb.status_seen[spq_pkg::ST_NOMATCH], sb.status_seen[spq_pkg::ST_FULL],
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
verif/tb_top.sv
